[rtl/cld_pkg.sv]
// Package for the content-length deframer: result kind codes, character
// constants and the header prefix table. No dependencies.

package cld_pkg;

  typedef enum logic [2:0] {
    KIND_BODY       = 3'd0,
    KIND_EMPTY      = 3'd1,
    KIND_NO_LENGTH  = 3'd2,
    KIND_IN_HEADER  = 3'd3,
    KIND_SHORT_BODY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_BODY   = 2'b10
  } phase_t;

  typedef enum logic [2:0] {
    DM_SKIP   = 3'b001,
    DM_DIGITS = 3'b010,
    DM_DONE   = 3'b100
  } digit_mode_t;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [4:0] PREFIX_LEN      = 5'd15;
  localparam logic [4:0] PREFIX_MISMATCH = 5'd16;

  // Characters of "Content-Length:" by position.
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[rtl/content_length_deframer.sv]
// A result goes through the input register, then the result register, to
// out_valid. One item per cycle while the result register is not stalled,
// set by the combinational header/body state update between the two
// registers. Items that give no result pass even while the result register is
// stalled. Reset (rst, synchronous, active high) empties both registers and
// returns the parser to the start of a header block with no length seen.

module content_length_deframer
  import cld_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] body_byte,
  output logic       frame_last
);

  localparam int PROD_BITS = LENGTH_BITS + 4;

  // Input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end;

  // Parser state
  phase_t                 phase, phase_next;
  logic [4:0]             prefix_pos, prefix_pos_next;
  logic                   has_content, has_content_next;
  logic                   pending_cr, pending_cr_next;
  logic                   after_nz, after_nz_next;
  digit_mode_t            dmode, dmode_next;
  logic [LENGTH_BITS-1:0] acc, acc_next;
  logic                   length_seen, length_seen_next;
  logic [LENGTH_BITS-1:0] body_length, body_length_next;
  logic [LENGTH_BITS-1:0] body_remaining, body_remaining_next;

  logic        res_want;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        advance;
  logic [3:0]  digit;
  logic [PROD_BITS-1:0] prod;

  assign digit = in_byte[3:0] - CH_ZERO[3:0];
  assign prod  = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + PROD_BITS'(digit);

  // An item with no result never waits for the result register.
  assign advance  = in_full && (!res_want || !out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_comb begin
    phase_next          = phase;
    prefix_pos_next     = prefix_pos;
    has_content_next    = has_content;
    pending_cr_next     = pending_cr;
    after_nz_next       = after_nz;
    dmode_next          = dmode;
    acc_next            = acc;
    length_seen_next    = length_seen;
    body_length_next    = body_length;
    body_remaining_next = body_remaining;
    res_want            = 1'b0;
    res_kind            = KIND_BODY;
    res_byte            = 8'd0;
    res_last            = 1'b0;

    if (phase == PH_BODY) begin
      res_want = 1'b1;
      if (in_end) begin
        res_kind = KIND_SHORT_BODY;
        res_last = 1'b1;
      end else begin
        res_byte = in_byte;
        res_last = (body_remaining == LENGTH_BITS'(1));
        body_remaining_next = body_remaining - LENGTH_BITS'(1);
      end
    end else if (in_end) begin
      res_want = 1'b1;
      res_kind = KIND_IN_HEADER;
      res_last = 1'b1;
    end else if (in_byte == CH_LF) begin
      if (!has_content) begin
        if (!length_seen) begin
          res_want = 1'b1;
          res_kind = KIND_NO_LENGTH;
          res_last = 1'b1;
        end else if (body_length == '0) begin
          res_want = 1'b1;
          res_kind = KIND_EMPTY;
          res_last = 1'b1;
        end else begin
          phase_next          = PH_BODY;
          body_remaining_next = body_length;
        end
      end else if (prefix_pos == PREFIX_LEN && after_nz) begin
        body_length_next = acc;
        length_seen_next = 1'b1;
      end
      prefix_pos_next  = 5'd0;
      has_content_next = 1'b0;
      pending_cr_next  = 1'b0;
      after_nz_next    = 1'b0;
      dmode_next       = DM_SKIP;
      acc_next         = '0;
    end else begin
      // A held CR that is not followed by LF counts as a line character.
      if (pending_cr) begin
        has_content_next = 1'b1;
        if (prefix_pos < PREFIX_LEN) begin
          prefix_pos_next = PREFIX_MISMATCH;
        end else if (prefix_pos == PREFIX_LEN) begin
          after_nz_next = 1'b1;
          if (dmode == DM_DIGITS) begin
            dmode_next = DM_DONE;
          end
        end
      end
      pending_cr_next = (in_byte == CH_CR);
      if (in_byte != CH_CR) begin
        has_content_next = 1'b1;
        if (prefix_pos_next < PREFIX_LEN) begin
          if (in_byte == prefix_char(prefix_pos_next[3:0])) begin
            prefix_pos_next = prefix_pos_next + 5'd1;
          end else begin
            prefix_pos_next = PREFIX_MISMATCH;
          end
        end else if (prefix_pos_next == PREFIX_LEN) begin
          after_nz_next = 1'b1;
          if (dmode_next == DM_SKIP && !is_space(in_byte)) begin
            dmode_next = DM_DIGITS;
          end
          if (dmode_next == DM_DIGITS) begin
            if (is_digit(in_byte)) begin
              if (prod[PROD_BITS-1:LENGTH_BITS] != 4'd0) begin
                acc_next = '1;
              end else begin
                acc_next = prod[LENGTH_BITS-1:0];
              end
            end else begin
              dmode_next = DM_DONE;
            end
          end
        end
      end
    end

    // Every result that closes a frame starts a fresh one.
    if (res_want && res_last) begin
      phase_next          = PH_HEADER;
      prefix_pos_next     = 5'd0;
      has_content_next    = 1'b0;
      pending_cr_next     = 1'b0;
      after_nz_next       = 1'b0;
      dmode_next          = DM_SKIP;
      acc_next            = '0;
      length_seen_next    = 1'b0;
      body_length_next    = '0;
      body_remaining_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      phase          <= PH_HEADER;
      prefix_pos     <= 5'd0;
      has_content    <= 1'b0;
      pending_cr     <= 1'b0;
      after_nz       <= 1'b0;
      dmode          <= DM_SKIP;
      acc            <= '0;
      length_seen    <= 1'b0;
      body_length    <= '0;
      body_remaining <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        phase          <= phase_next;
        prefix_pos     <= prefix_pos_next;
        has_content    <= has_content_next;
        pending_cr     <= pending_cr_next;
        after_nz       <= after_nz_next;
        dmode          <= dmode_next;
        acc            <= acc_next;
        length_seen    <= length_seen_next;
        body_length    <= body_length_next;
        body_remaining <= body_remaining_next;
      end
      if (advance && res_want) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
      in_end  <= stream_end;
    end
    if (advance && res_want) begin
      kind       <= res_kind;
      body_byte  <= res_byte;
      frame_last <= res_last;
    end
  end

endmodule

[rtl/cld_checker.sv]
// Port-level checks for the content-length deframer, bound to the top level.
// Depends on cld_pkg.

module cld_checker
  import cld_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [7:0] body_byte,
  input logic       frame_last
);

  // A stalled result item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(body_byte)
                              && $stable(frame_last))
    else $error("stalled result item changed");

  // Empty frames and errors always close the frame.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BODY |-> frame_last)
    else $error("non-body result without frame_last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BODY |-> body_byte == 8'd0)
    else $error("non-body result carries a byte");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_BODY || kind == KIND_EMPTY || kind == KIND_NO_LENGTH
                  || kind == KIND_IN_HEADER || kind == KIND_SHORT_BODY)
    else $error("result kind out of range");

  // The input side only waits when a result is already held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register free");

endmodule

bind content_length_deframer cld_checker u_cld_checker (.*);

[tb/sv/content_length_deframer_test.sv]
// Self-checking testbench for content_length_deframer: drives framed byte
// streams through the valid/stall handshake and checks every result item
// against a bit-accurate model of the deframer held here. Depends on cld_pkg.

module content_length_deframer_test;
  import cld_pkg::*;

  localparam int LEN_W = 32;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [8*15-1:0] PREFIX_TEXT = "Content-Length:";
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       stream_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] body_byte;
  logic       frame_last;

  content_length_deframer #(.LENGTH_BITS(LEN_W)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .body_byte  (body_byte),
    .frame_last (frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Deframer model state.
  phase_t           parse_phase;
  logic [4:0]       match_pos;
  logic             line_used;
  logic             cr_held;
  logic             has_tail;
  digit_mode_t      num_mode;
  logic [LEN_W-1:0] acc;
  logic             len_seen;
  logic [LEN_W-1:0] body_len;
  logic [LEN_W-1:0] remaining;

  frame_result_t deframed_due[$];
  int            fail_count = 0;
  int            items_sent = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  logic          hold_req = 1'b0;
  int            hold_count = 0;
  int            cycle_count = 0;

  task automatic clear_line();
    match_pos = '0;
    line_used = 1'b0;
    cr_held   = 1'b0;
    has_tail  = 1'b0;
    num_mode  = DM_SKIP;
    acc       = '0;
  endtask

  task automatic new_frame();
    parse_phase = PH_HEADER;
    clear_line();
    len_seen  = 1'b0;
    body_len  = '0;
    remaining = '0;
  endtask

  task automatic note_result(input kind_t k, input logic [7:0] b, input logic l);
    frame_result_t r;
    r.kind = k;
    r.data = b;
    r.last = l;
    deframed_due.insert(deframed_due.size(), r);
  endtask

  task automatic absorb_line_char(input logic [7:0] c);
    logic [LEN_W-1:0] digit;
    logic             blank;
    blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    line_used = 1'b1;
    if (match_pos < PREFIX_LEN) begin
      if (c == PREFIX_TEXT[8*(14 - int'(match_pos)) +: 8]) match_pos = match_pos + 5'd1;
      else match_pos = PREFIX_MISMATCH;
    end else if (match_pos == PREFIX_LEN) begin
      has_tail = 1'b1;
      if (num_mode == DM_SKIP && !blank) num_mode = DM_DIGITS;
      if (num_mode == DM_DIGITS) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          digit = LEN_W'(c - CH_ZERO);
          if (acc > (LEN_MAX - digit) / 10) acc = LEN_MAX;
          else acc = acc * 10 + digit;
        end else begin
          num_mode = DM_DONE;
        end
      end
    end
  endtask

  // Advances the model by one accepted item and records any result it causes.
  task automatic deframe_byte(input logic [7:0] c, input logic e);
    logic last;
    if (parse_phase == PH_BODY) begin
      if (e) begin
        new_frame();
        note_result(KIND_SHORT_BODY, 8'h00, 1'b1);
      end else begin
        remaining = remaining - 1;
        last = (remaining == 0);
        if (last) new_frame();
        note_result(KIND_BODY, c, last);
      end
    end else if (e) begin
      new_frame();
      note_result(KIND_IN_HEADER, 8'h00, 1'b1);
    end else if (c == CH_LF) begin
      cr_held = 1'b0;
      if (!line_used) begin
        if (!len_seen) begin
          new_frame();
          note_result(KIND_NO_LENGTH, 8'h00, 1'b1);
        end else if (body_len == 0) begin
          new_frame();
          note_result(KIND_EMPTY, 8'h00, 1'b1);
        end else begin
          clear_line();
          parse_phase = PH_BODY;
          remaining = body_len;
        end
      end else begin
        if (match_pos == PREFIX_LEN && has_tail) begin
          body_len = acc;
          len_seen = 1'b1;
        end
        clear_line();
      end
    end else begin
      // A held CR that is not followed by LF counts as a line character.
      if (cr_held) begin
        cr_held = 1'b0;
        absorb_line_char(CH_CR);
      end
      if (c == CH_CR) cr_held = 1'b1;
      else absorb_line_char(c);
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    stream_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b, e);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic crlf();
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
  endtask

  task automatic end_line(input logic may_double);
    int r;
    r = $urandom_range(9);
    if (may_double && r == 0) send_item(CH_CR, 1'b0);
    if (r < 7) send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
  endtask

  task automatic random_length_line(input int unsigned v);
    int nblank;
    nblank = $urandom_range(2);
    send_text("Content-Length:");
    for (int k = 0; k < nblank; k++) begin
      case ($urandom_range(4))
        0:       send_item(CH_SP, 1'b0);
        1:       send_item(CH_TAB, 1'b0);
        2:       send_item(CH_VT, 1'b0);
        3:       send_item(CH_FF, 1'b0);
        default: send_item(CH_CR, 1'b0);
      endcase
    end
    if ($urandom_range(3) == 0) send_item(CH_ZERO, 1'b0);
    send_text($sformatf("%0d", v));
    if ($urandom_range(3) == 0) send_text(";x");
    end_line(1'b1);
  endtask

  task automatic random_frame();
    int unsigned len;
    int          extra;
    int          where;
    int          n;
    logic        with_len;
    logic [7:0]  c;
    len = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(8);
    with_len = ($urandom_range(9) != 0);
    extra = $urandom_range(2);
    where = $urandom_range(extra);
    for (int i = 0; i <= extra; i++) begin
      if (with_len && i == where) begin
        // Sometimes a decoy length comes first; the later line must win.
        if ($urandom_range(5) == 0) random_length_line($urandom_range(999));
        random_length_line(len);
      end else begin
        n = $urandom_range(10, 1);
        for (int j = 0; j < n; j++) begin
          c = ($urandom_range(15) == 0) ? CH_CR : 8'($urandom_range(126, 32));
          send_item(c, 1'b0);
        end
        end_line(1'b1);
      end
    end
    if ($urandom_range(19) == 0) begin
      send_item(8'($urandom_range(255)), 1'b1);
    end else begin
      end_line(1'b0);
      if (with_len && len > 0) begin
        n = ($urandom_range(14) == 0) ? $urandom_range(len - 1) : len;
        for (int j = 0; j < n; j++) send_item(8'($urandom_range(255)), 1'b0);
        if (n < len) send_item(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  task automatic test_basic_frame();
    send_text("X-Junk: ");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    crlf();
    send_text("Content-Length: 3");
    crlf();
    crlf();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_LF, 1'b0);
  endtask

  task automatic test_empty_and_missing();
    send_text("Content-Length: 0");
    crlf();
    crlf();
    send_text("Content-Type: text");
    crlf();
    crlf();
    send_item(CH_LF, 1'b0);
  endtask

  task automatic test_stream_closed();
    // Closed before any byte of the frame, then closed part way into a line.
    send_item(8'hA5, 1'b1);
    send_text("Content-Le");
    send_item(8'h5A, 1'b1);
    send_text("Content-Length: 4");
    crlf();
    crlf();
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'hFF, 1'b1);
    // The bytes after the close begin a fresh frame.
    send_text("Content-Length: 1");
    crlf();
    crlf();
    send_text("Z");
  endtask

  task automatic test_prefix_variants();
    send_text("Content-Length:");
    crlf();
    crlf();
    send_text("content-length: 2");
    crlf();
    crlf();
    send_text("Content-Length:x");
    crlf();
    crlf();
    send_text("Content-Length:+5");
    crlf();
    crlf();
    send_text("Content-Length:");
    send_item(CH_VT, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_FF, 1'b0);
    send_text(" 2abc");
    send_item(CH_LF, 1'b0);
    send_text("Content-Length:");
    send_item(CH_CR, 1'b0);
    send_text("1");
    send_item(CH_CR, 1'b0);
    crlf();
    send_text("X");
    send_item(CH_CR, 1'b0);
    send_text("Y");
    crlf();
    // A line holding only a CR is not blank and does not end the header.
    send_item(CH_CR, 1'b0);
    crlf();
    crlf();
    send_item(CH_CR, 1'b0);
  endtask

  task automatic test_saturation();
    send_text("Content-Length: 4294967296");
    crlf();
    send_text("Content-Length: 00099999999999999");
    crlf();
    crlf();
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    send_text("Content-Length: 40");
    crlf();
    crlf();
    for (int j = 0; j < 40; j++) send_item(8'($urandom_range(255)), 1'b0);
    hold_req <= 1'b0;
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    int n;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(4, 1);
        for (int j = 0; j < n; j++)
          send_item(8'($urandom_range(255)), $urandom_range(5) == 0);
      end
      random_frame();
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (deframed_due.size() == 0) begin
        $display("%0t: result with none expected, kind %0d byte %02h last %0b",
                 $time, kind, body_byte, frame_last);
        fail_count++;
      end else begin
        want = deframed_due.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d, actual %0d", $time, want.kind, kind);
          fail_count++;
        end
        if (body_byte !== want.data) begin
          $display("%0t: body_byte expected %02h, actual %02h", $time, want.data, body_byte);
          fail_count++;
        end
        if (frame_last !== want.last) begin
          $display("%0t: frame_last expected %0b, actual %0b", $time, want.last, frame_last);
          fail_count++;
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!hold_req) hold_count <= 0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    new_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 31;
    stall_pct <= 83;
    test_basic_frame();
    test_empty_and_missing();
    test_stream_closed();
    test_prefix_variants();
    test_saturation();
    test_random_traffic(110);

    send_idle_pct = 83;
    stall_pct <= 31;
    test_random_traffic(100);

    send_idle_pct = 0;
    stall_pct <= 0;
    test_backpressure();
    test_random_traffic(100);
    in_valid <= 1'b0;

    while (deframed_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cld_pkg.sv
rtl/content_length_deframer.sv
rtl/cld_checker.sv
tb/sv/content_length_deframer_test.sv
